FILE: hdl/rcpw_pkg.sv
package rcpw_pkg;

  // Field widths fixed by the item formats.
  localparam int PIN_W = 4;
  localparam int TIME_W = 32;
  localparam int WIDTH_W = 16;
  localparam int RD_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Default channel count for the top level.
  localparam int NUM_CHANNELS_DEFAULT = 4;

  // Reset values of the configuration registers.
  localparam logic [WIDTH_W-1:0] MIN_HIGH_RESET = 16'd920;
  localparam logic [WIDTH_W-1:0] MAX_HIGH_RESET = 16'd2100;
  localparam logic [WIDTH_W-1:0] MIN_LOW_RESET = 16'd11530;
  localparam logic [WIDTH_W-1:0] MAX_LOW_RESET = 16'd12710;
  localparam logic [PIN_W-1:0] ENABLE_RESET = 4'hF;

  // Width reported before a channel has seen its first good pulse.
  localparam logic [WIDTH_W-1:0] NO_WIDTH = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_EN = 3'd4;

  typedef struct packed {
    logic [PIN_W-1:0]  pin_levels;
    logic [TIME_W-1:0] now_us;
    logic [RD_W-1:0]   read_channel;
  } in_item_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] read_width;
    logic [PIN_W-1:0]   width_updated;
  } out_item_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] min_high_us;
    logic [WIDTH_W-1:0] max_high_us;
    logic [WIDTH_W-1:0] min_low_us;
    logic [WIDTH_W-1:0] max_low_us;
    logic [PIN_W-1:0]   channel_enable;
  } cfg_t;

  // True when a wrapped time difference lies inside [lo, hi].
  function automatic logic in_window(input logic [TIME_W-1:0] dt,
                                     input logic [WIDTH_W-1:0] lo,
                                     input logic [WIDTH_W-1:0] hi);
    logic [TIME_W-1:0] lo_ext;
    logic [TIME_W-1:0] hi_ext;
    lo_ext = TIME_W'(lo);
    hi_ext = TIME_W'(hi);
    return (dt >= lo_ext) && (dt <= hi_ext);
  endfunction

endpackage

FILE: hdl/rcpw_cfg.sv
module rcpw_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rcpw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcpw_pkg::CFG_DATA_W-1:0]    cfg_data,
  output rcpw_pkg::cfg_t                     cfg
);

  rcpw_pkg::cfg_t regs;

  // Register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.min_high_us    <= rcpw_pkg::MIN_HIGH_RESET;
      regs.max_high_us    <= rcpw_pkg::MAX_HIGH_RESET;
      regs.min_low_us     <= rcpw_pkg::MIN_LOW_RESET;
      regs.max_low_us     <= rcpw_pkg::MAX_LOW_RESET;
      regs.channel_enable <= rcpw_pkg::ENABLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rcpw_pkg::REG_MIN_HIGH: regs.min_high_us <= cfg_data;
        rcpw_pkg::REG_MAX_HIGH: regs.max_high_us <= cfg_data;
        rcpw_pkg::REG_MIN_LOW:  regs.min_low_us <= cfg_data;
        rcpw_pkg::REG_MAX_LOW:  regs.max_low_us <= cfg_data;
        rcpw_pkg::REG_CHAN_EN:  regs.channel_enable <= cfg_data[rcpw_pkg::PIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

FILE: hdl/rcpw_chan.sv
module rcpw_chan (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  logic                               enable,
  input  logic                               level,
  input  logic                               prev_level,
  input  logic [rcpw_pkg::TIME_W-1:0]        now_us,
  input  rcpw_pkg::cfg_t                     cfg,
  output logic [rcpw_pkg::WIDTH_W-1:0]       good_width_next,
  output logic                               updated
);

  logic [rcpw_pkg::TIME_W-1:0]  rise_stamp;
  logic [rcpw_pkg::TIME_W-1:0]  fall_stamp;
  logic                         armed;
  logic [rcpw_pkg::WIDTH_W-1:0] good_width;

  logic [rcpw_pkg::TIME_W-1:0]  rise_stamp_next;
  logic [rcpw_pkg::TIME_W-1:0]  fall_stamp_next;
  logic                         armed_next;
  logic [rcpw_pkg::TIME_W-1:0]  dt;
  logic                         changed;

  // Edge handling for one sample of this channel's pin.
  always_comb begin
    changed         = enable && (level != prev_level);
    rise_stamp_next = rise_stamp;
    fall_stamp_next = fall_stamp;
    armed_next      = armed;
    good_width_next = good_width;
    updated         = 1'b0;
    dt              = level ? (now_us - fall_stamp) : (now_us - rise_stamp);
    if (changed) begin
      if (level) begin
        // Rising edge: arm only after a low gap inside the low window.
        rise_stamp_next = now_us;
        armed_next = rcpw_pkg::in_window(dt, cfg.min_low_us, cfg.max_low_us);
      end else begin
        // Falling edge: an armed pulse of legal width is stored.
        fall_stamp_next = now_us;
        if (armed && rcpw_pkg::in_window(dt, cfg.min_high_us, cfg.max_high_us)) begin
          good_width_next = dt[rcpw_pkg::WIDTH_W-1:0];
          armed_next      = 1'b0;
          updated         = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_stamp <= '0;
      fall_stamp <= '0;
      armed      <= 1'b0;
      good_width <= rcpw_pkg::NO_WIDTH;
    end else if (advance) begin
      rise_stamp <= rise_stamp_next;
      fall_stamp <= fall_stamp_next;
      armed      <= armed_next;
      good_width <= good_width_next;
    end
  end

  // A width is only stored on a falling edge.
  assert property (@(posedge clk) disable iff (rst) updated |-> (!level && prev_level))
    else $error("width stored without a falling edge");

  // Storing a width always leaves the channel disarmed.
  assert property (@(posedge clk) disable iff (rst) (advance && updated) |=> !armed)
    else $error("channel still armed after storing a width");

endmodule

FILE: hdl/rc_pulse_width_capture.sv
// Items pass the input register, then the output register; one item per cycle
// unless out_stall holds the output. The pin state update and the result are one
// register-to-register pass, so the next sample sees this sample's edges.
// Reset (rst, synchronous, active high) empties both stages, restores the
// configuration defaults, clears stamps and arming, and sets widths to 65535.
module rc_pulse_width_capture #(
  parameter int NUM_CHANNELS = rcpw_pkg::NUM_CHANNELS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rcpw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcpw_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  rcpw_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rcpw_pkg::out_item_t                out_data
);

  // Only channels that have a pin bit do any work or can be read.
  localparam int ACT_CH = (NUM_CHANNELS < rcpw_pkg::PIN_W) ? NUM_CHANNELS : rcpw_pkg::PIN_W;

  rcpw_pkg::cfg_t               cfg;
  rcpw_pkg::in_item_t           in_reg;
  logic                         in_reg_valid;
  logic [rcpw_pkg::PIN_W-1:0]   prev_levels;
  logic                         advance;
  logic [rcpw_pkg::WIDTH_W-1:0] width_next [ACT_CH];
  logic [ACT_CH-1:0]            chan_updated;
  logic [rcpw_pkg::RD_W-1:0]    rd_sel;
  rcpw_pkg::out_item_t          result;

  rcpw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held item moves on when the output register is free or being emptied.
  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_data;
    end
  end

  // Pin levels of the last processed sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels <= '0;
    end else if (advance) begin
      prev_levels <= in_reg.pin_levels;
    end
  end

  // Per-channel edge timing.
  for (genvar i = 0; i < ACT_CH; i++) begin : g_chan
    rcpw_chan u_chan (
      .clk             (clk),
      .rst             (rst),
      .advance         (advance),
      .enable          (cfg.channel_enable[i]),
      .level           (in_reg.pin_levels[i]),
      .prev_level      (prev_levels[i]),
      .now_us          (in_reg.now_us),
      .cfg             (cfg),
      .good_width_next (width_next[i]),
      .updated         (chan_updated[i])
    );
  end

  // Result: clamp the read channel and pick its updated width.
  always_comb begin
    if (int'(in_reg.read_channel) >= ACT_CH) begin
      rd_sel = rcpw_pkg::RD_W'(ACT_CH - 1);
    end else begin
      rd_sel = in_reg.read_channel;
    end
    result.read_width    = rcpw_pkg::NO_WIDTH;
    result.width_updated = '0;
    for (int i = 0; i < ACT_CH; i++) begin
      if (rd_sel == rcpw_pkg::RD_W'(i)) begin
        result.read_width = width_next[i];
      end
      result.width_updated[i] = chan_updated[i];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // Every processed sample leaves a result behind.
  assert property (@(posedge clk) disable iff (rst) advance |=> out_valid)
    else $error("processed sample produced no result");

  // The input side only stalls while an item is held.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> in_reg_valid)
    else $error("input stalled with empty input register");

  // Nothing is processed while the output holds a result that is not taken.
  assert property (@(posedge clk) disable iff (rst) (out_valid && out_stall) |-> !advance)
    else $error("result overwritten while stalled");

endmodule

FILE: tb/sv/tb_rc_pulse_width_capture.sv
`timescale 1ns / 1ps

module tb_rc_pulse_width_capture;
  import rcpw_pkg::*;

  localparam int NCH = NUM_CHANNELS_DEFAULT;
  localparam int NUM_PHASES = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int HOLD_AFTER = 1400;
  localparam int HOLD_CYCLES = 120;
  localparam int SHOWN_MISMATCHES = 10;

  // Tracks per-channel edge stamps and widths and keeps the results still owed.
  class pulse_width_board;
    cfg_t cfg;
    logic [PIN_W-1:0] last_levels;
    logic [TIME_W-1:0] rise_at[NCH];
    logic [TIME_W-1:0] fall_at[NCH];
    bit armed_ch[NCH];
    logic [WIDTH_W-1:0] width_kept[NCH];
    out_item_t due_results[$];
    int mismatches;
    int compared;
    int captures;

    function new();
      cfg = cfg_t'{MIN_HIGH_RESET, MAX_HIGH_RESET, MIN_LOW_RESET, MAX_LOW_RESET, ENABLE_RESET};
      last_levels = '0;
      for (int ch = 0; ch < NCH; ch++) begin
        rise_at[ch] = '0;
        fall_at[ch] = '0;
        armed_ch[ch] = 1'b0;
        width_kept[ch] = NO_WIDTH;
      end
      mismatches = 0;
      compared = 0;
      captures = 0;
    endfunction

    // Apply one accepted sample to the channel state and queue the result it owes.
    function void accept_sample(in_item_t smp);
      logic [PIN_W-1:0] changed;
      logic [PIN_W-1:0] stored;
      logic [TIME_W-1:0] dt;
      int rd;
      out_item_t want;
      changed = (smp.pin_levels ^ last_levels) & cfg.channel_enable;
      last_levels = smp.pin_levels;
      stored = '0;
      for (int ch = 0; ch < NCH && ch < PIN_W; ch++) begin
        if (changed[ch]) begin
          if (smp.pin_levels[ch]) begin
            // A rising edge arms the channel only after a low gap inside the window.
            dt = smp.now_us - fall_at[ch];
            rise_at[ch] = smp.now_us;
            armed_ch[ch] = (dt >= TIME_W'(cfg.min_low_us)) && (dt <= TIME_W'(cfg.max_low_us));
          end else begin
            dt = smp.now_us - rise_at[ch];
            fall_at[ch] = smp.now_us;
            if (armed_ch[ch] && dt >= TIME_W'(cfg.min_high_us) &&
                dt <= TIME_W'(cfg.max_high_us)) begin
              width_kept[ch] = dt[WIDTH_W-1:0];
              armed_ch[ch] = 1'b0;
              stored[ch] = 1'b1;
            end
          end
        end
      end
      rd = int'(smp.read_channel);
      if (rd >= NCH) rd = NCH - 1;
      want.read_width = width_kept[rd];
      want.width_updated = stored;
      due_results.push_back(want);
    endfunction

    // Compare one result transfer against the oldest owed result.
    function void compare_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("unexpected result: width %0d mask %b", got.read_width, got.width_updated);
      end else begin
        want = due_results.pop_front();
        compared++;
        captures += $countones(want.width_updated);
        if (got.read_width !== want.read_width || got.width_updated !== want.width_updated) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("result %0d: expected width %0d mask %b, got width %0d mask %b",
                     compared, want.read_width, want.width_updated,
                     got.read_width, got.width_updated);
        end
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  pulse_width_board board;
  int accepted_samples = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 65;
  int unsigned cycle_count = 0;

  // Pulse train generator state.
  logic [PIN_W-1:0] pin_state;
  int unsigned until_toggle[PIN_W];
  logic [TIME_W-1:0] clock_us;

  rc_pulse_width_capture dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.compare_result(out_data);
  end

  // Receiver stalls at random, with one long hold-off so the block backs up.
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && accepted_samples >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Span until the next toggle: mostly inside the window, often on or just past its edges.
  function automatic int unsigned pick_span(logic [WIDTH_W-1:0] lo, logic [WIDTH_W-1:0] hi);
    int unsigned span;
    case ($urandom_range(9))
      0: span = lo;
      1: span = hi;
      2: span = (lo == 0) ? 1 : lo - 1;
      3: span = hi + 1;
      4: span = $urandom_range(65535);
      default: span = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(65535);
    endcase
    if (span == 0) span = 1;
    return span;
  endfunction

  // Advance the pulse trains to the next edge, or to a sample between edges.
  function automatic in_item_t next_pulse_sample();
    in_item_t smp;
    int unsigned soonest;
    int unsigned step;
    soonest = until_toggle[0];
    for (int ch = 1; ch < PIN_W; ch++)
      if (until_toggle[ch] < soonest) soonest = until_toggle[ch];
    step = ($urandom_range(9) < 2) ? $urandom_range(soonest - 1, 0) : soonest;
    clock_us += step;
    for (int ch = 0; ch < PIN_W; ch++) begin
      until_toggle[ch] -= step;
      if (until_toggle[ch] == 0) begin
        pin_state[ch] = ~pin_state[ch];
        until_toggle[ch] = pin_state[ch] ?
            pick_span(board.cfg.min_high_us, board.cfg.max_high_us) :
            pick_span(board.cfg.min_low_us, board.cfg.max_low_us);
      end
    end
    smp.pin_levels = pin_state;
    smp.now_us = clock_us;
    smp.read_channel = RD_W'($urandom_range(3));
    return smp;
  endfunction

  // Offer one sample, with random idle cycles ahead of it, and wait for its transfer.
  task automatic send_sample(input in_item_t smp);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= smp;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.accept_sample(smp);
    accepted_samples++;
  endtask

  task automatic offer(input logic [PIN_W-1:0] pins, input logic [TIME_W-1:0] stamp,
                       input logic [RD_W-1:0] rd);
    in_item_t smp;
    smp.pin_levels = pins;
    smp.now_us = stamp;
    smp.read_channel = rd;
    send_sample(smp);
  endtask

  // Stop offering and wait until every owed result has arrived.
  task automatic drain(input int unsigned max_wait);
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (board.pending() != 0 && waited < max_wait) begin
      @(posedge clk);
      waited++;
    end
    repeat (3) @(posedge clk);
  endtask

  // Write all five registers on consecutive cycles while the block is idle.
  task automatic apply_config(input cfg_t c);
    cfg_we <= 1'b1;
    cfg_index <= REG_MIN_HIGH;
    cfg_data <= c.min_high_us;
    @(posedge clk);
    cfg_index <= REG_MAX_HIGH;
    cfg_data <= c.max_high_us;
    @(posedge clk);
    cfg_index <= REG_MIN_LOW;
    cfg_data <= c.min_low_us;
    @(posedge clk);
    cfg_index <= REG_MAX_LOW;
    cfg_data <= c.max_low_us;
    @(posedge clk);
    cfg_index <= REG_CHAN_EN;
    cfg_data <= CFG_DATA_W'(c.channel_enable);
    @(posedge clk);
    cfg_we <= 1'b0;
    board.cfg = c;
  endtask

  initial begin : main
    cfg_t plan[NUM_PHASES];
    int phase_len[NUM_PHASES];
    int sent;
    in_item_t smp;
    board = new();

    // Register settings per phase; the first phase runs on the reset values.
    plan[0] = board.cfg;
    plan[1] = cfg_t'{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 4'hF};
    plan[2] = cfg_t'{16'd2100, 16'd920, 16'd0, 16'hFFFF, 4'b0101};
    plan[3] = cfg_t'{16'd1500, 16'd1500, 16'd12000, 16'd12000, 4'b1010};
    plan[4].min_high_us = WIDTH_W'($urandom_range(3000));
    plan[4].max_high_us = plan[4].min_high_us + WIDTH_W'($urandom_range(3000));
    plan[4].min_low_us = WIDTH_W'($urandom_range(60000));
    plan[4].max_low_us = plan[4].min_low_us + WIDTH_W'($urandom_range(5000));
    plan[4].channel_enable = PIN_W'($urandom_range(15));
    plan[5] = cfg_t'{16'd0, 16'hFFFF, 16'd12710, 16'd11530, 4'hF};
    plan[6] = cfg_t'{16'd920, 16'd2100, 16'd11530, 16'd12710, 4'h0};
    plan[7] = cfg_t'{MIN_HIGH_RESET, MAX_HIGH_RESET, MIN_LOW_RESET, MAX_LOW_RESET,
                     ENABLE_RESET};
    phase_len = '{330, 300, 250, 250, 300, 250, 60, 210};

    pin_state = '0;
    clock_us = 32'hFF80_0000;
    for (int ch = 0; ch < PIN_W; ch++) until_toggle[ch] = $urandom_range(3000, 1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed samples on the reset windows: window edges, one past them,
    // a miss that keeps the channel armed, staggered channels, and wrapped time.
    offer(4'h0, 32'd0, 2'd0);
    offer(4'hF, 32'd11530, 2'd1);
    offer(4'h0, 32'd12450, 2'd2);
    offer(4'hF, 32'd25160, 2'd3);
    offer(4'h0, 32'd27260, 2'd0);
    offer(4'hF, 32'd38789, 2'd1);
    offer(4'h0, 32'd40289, 2'd2);
    offer(4'hF, 32'd53000, 2'd3);
    offer(4'h0, 32'd54000, 2'd0);
    offer(4'hF, 32'd66000, 2'd1);
    offer(4'h0, 32'd66919, 2'd2);
    offer(4'hF, 32'd78919, 2'd3);
    offer(4'h0, 32'd81020, 2'd0);
    offer(4'b0101, 32'd93020, 2'd1);
    offer(4'hF, 32'd93520, 2'd2);
    offer(4'b1010, 32'd94520, 2'd3);
    offer(4'h0, 32'd95020, 2'd0);
    offer(4'hF, 32'hFFFF_E000, 2'd1);
    offer(4'h0, 32'hFFFF_F000, 2'd2);
    offer(4'hF, 32'd7904, 2'd3);
    offer(4'h0, 32'd9704, 2'd0);
    offer(4'hF, 32'd9704, 2'd1);
    offer(4'h0, 32'hFFFF_FFFF, 2'd2);

    // Random pulse trains per register setting, with some noise samples mixed in.
    sent = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain(10000);
        apply_config(plan[p]);
      end
      for (int k = 0; k < phase_len[p]; k++) begin
        if (sent < 650) begin
          send_idle_pct = 9;
          recv_idle_pct = 65;
        end else if (sent < 1300) begin
          send_idle_pct = 65;
          recv_idle_pct = 9;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if ($urandom_range(99) < 6) begin
          smp.pin_levels = PIN_W'($urandom_range(15));
          smp.now_us = $urandom_range(1) ? $urandom() : clock_us + $urandom_range(20000);
          smp.read_channel = RD_W'($urandom_range(3));
        end else begin
          smp = next_pulse_sample();
        end
        send_sample(smp);
        sent++;
      end
    end

    drain(20000);
    $display("Sent %0d samples through %0d register settings; %0d results checked.",
             accepted_samples, NUM_PHASES, board.compared);
    $display("%0d pulse widths were captured; %0d mismatches, %0d results missing.",
             board.captures, board.mismatches, board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/rcpw_pkg.sv
hdl/rcpw_cfg.sv
hdl/rcpw_chan.sv
hdl/rc_pulse_width_capture.sv
tb/sv/tb_rc_pulse_width_capture.sv
